FILE: hw/rtl/aide_pkg.sv
// shared types and codes for the array insert/delete engine
package aide_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_UPDATE,
    CM_ROTATE
  } cell_mode_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         index;
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } out_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/aide_cell.sv
// one list entry cell with moves to and from its neighbors
module aide_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  aide_pkg::cell_ctrl_t              ctrl,
  input  logic signed [aide_pkg::DATA_W-1:0] left_q,
  input  logic signed [aide_pkg::DATA_W-1:0] right_q,
  input  logic signed [aide_pkg::DATA_W-1:0] head_q,
  output logic signed [aide_pkg::DATA_W-1:0] q
);

  localparam logic [aide_pkg::CNT_W-1:0] MY_IDX = aide_pkg::CNT_W'(IDX);
  localparam logic [aide_pkg::CNT_W-1:0] MY_NXT = aide_pkg::CNT_W'(IDX + 1);

  logic signed [aide_pkg::DATA_W-1:0] q_r;
  logic signed [aide_pkg::DATA_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (ctrl.mode)
      aide_pkg::CM_INSERT: begin
        if (MY_IDX == ctrl.pos) begin
          q_nxt = ctrl.value;
        end else if (MY_IDX > ctrl.pos && MY_IDX <= ctrl.cnt) begin
          q_nxt = left_q;
        end
      end
      aide_pkg::CM_DELETE: begin
        if (MY_IDX >= ctrl.pos && MY_NXT < ctrl.cnt) begin
          q_nxt = right_q;
        end
      end
      aide_pkg::CM_UPDATE: begin
        if (MY_IDX == ctrl.pos) begin
          q_nxt = ctrl.value;
        end
      end
      aide_pkg::CM_ROTATE: begin
        if (MY_NXT < ctrl.cnt) begin
          q_nxt = right_q;
        end else if (MY_NXT == ctrl.cnt) begin
          q_nxt = head_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

FILE: hw/rtl/array_insert_delete_engine.sv
// top level of the array insert/delete engine: command decode and cell chain
// usage:
//   a command transfer happens on a rising edge with start high and busy low;
//   in_item carries op, position and value
//   append, insert, delete, update and unknown ops give one result in the cycle
//   after the transfer, with status and the count after the command
//   read all on a non-empty list raises busy and streams one entry per cycle,
//   the first passing the read state register and then the output register,
//   as many entries as the count, last on the final one; busy drops as the
//   final result appears, so the next command can transfer at the edge that ends it
//   read all on an empty list gives one result with the empty status
//   edits move all cells at the same clock edge; the readout rotates the
//   cells through the head cell, which leaves the list in order when it ends
//   out_valid marks each result for exactly one cycle; there is no stall
//   reset clears the count and the sequencer; cell contents are not cleared
module array_insert_delete_engine #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  aide_pkg::in_t  in_item,
  output logic           out_valid,
  output aide_pkg::out_t out_item
);

  localparam logic [aide_pkg::CNT_W-1:0] CAP = aide_pkg::CNT_W'(CAPACITY);

  aide_pkg::state_t state_r, state_nxt;
  logic [aide_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [aide_pkg::POS_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  aide_pkg::out_t             out_r, out_nxt;
  aide_pkg::cell_ctrl_t       ctrl;
  logic                       accept;
  logic                       rd_last;
  logic [aide_pkg::CNT_W-1:0] pos_ext;

  logic signed [aide_pkg::DATA_W-1:0] cell_q [CAPACITY];

  assign accept  = start && (state_r == aide_pkg::S_IDLE);
  assign pos_ext = {1'b0, in_item.position};
  assign rd_last = ({1'b0, rd_idx_r} + 1'b1) == cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aide_pkg::S_IDLE: begin
        if (accept && in_item.op == aide_pkg::OP_READ && cnt_r != '0) begin
          state_nxt = aide_pkg::S_READ;
        end
      end
      aide_pkg::S_READ: begin
        if (rd_last) begin
          state_nxt = aide_pkg::S_IDLE;
        end
      end
      default: state_nxt = aide_pkg::S_IDLE;
    endcase
  end

  // outputs and cell control
  always_comb begin
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    ctrl          = '0;
    ctrl.mode     = aide_pkg::CM_HOLD;
    ctrl.cnt      = cnt_r;
    ctrl.pos      = pos_ext;
    ctrl.value    = in_item.value;
    case (state_r)
      aide_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = aide_pkg::ST_OK;
          out_nxt.last   = 1'b1;
          case (in_item.op)
            aide_pkg::OP_APPEND: begin
              if (cnt_r >= CAP) begin
                out_nxt.status = aide_pkg::ST_FULL;
              end else begin
                ctrl.mode = aide_pkg::CM_INSERT;
                ctrl.pos  = cnt_r;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            aide_pkg::OP_INSERT: begin
              if (cnt_r >= CAP) begin
                out_nxt.status = aide_pkg::ST_FULL;
              end else if (pos_ext > cnt_r) begin
                out_nxt.status = aide_pkg::ST_RANGE;
              end else begin
                ctrl.mode = aide_pkg::CM_INSERT;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            aide_pkg::OP_DELETE: begin
              if (pos_ext >= cnt_r) begin
                out_nxt.status = aide_pkg::ST_RANGE;
              end else begin
                ctrl.mode = aide_pkg::CM_DELETE;
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            aide_pkg::OP_UPDATE: begin
              if (pos_ext >= cnt_r) begin
                out_nxt.status = aide_pkg::ST_RANGE;
              end else begin
                ctrl.mode = aide_pkg::CM_UPDATE;
              end
            end
            aide_pkg::OP_READ: begin
              if (cnt_r == '0) begin
                out_nxt.status = aide_pkg::ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rd_idx_nxt    = '0;
              end
            end
            default: out_nxt.status = aide_pkg::ST_OK;
          endcase
          out_nxt.count = cnt_nxt;
        end
      end
      aide_pkg::S_READ: begin
        ctrl.mode      = aide_pkg::CM_ROTATE;
        out_valid_nxt  = 1'b1;
        out_nxt.data   = cell_q[0];
        out_nxt.index  = rd_idx_r;
        out_nxt.status = aide_pkg::ST_OK;
        out_nxt.count  = cnt_r;
        out_nxt.last   = rd_last;
        rd_idx_nxt     = rd_idx_r + 1'b1;
      end
      default: ctrl.mode = aide_pkg::CM_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aide_pkg::S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [aide_pkg::DATA_W-1:0] left_d;
    logic signed [aide_pkg::DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    aide_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .left_q (left_d),
      .right_q(right_d),
      .head_q (cell_q[0]),
      .q      (cell_q[i])
    );
  end

  assign busy      = (state_r == aide_pkg::S_READ);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP)
    else $error("count above capacity");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aide_pkg::S_READ) |-> ({1'b0, rd_idx_r} < cnt_r))
    else $error("readout index past count");

  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op != aide_pkg::OP_READ) |=> (out_valid_r && out_r.last))
    else $error("edit transfer without result");

  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aide_pkg::S_READ && rd_last) |=>
      (state_r == aide_pkg::S_IDLE && out_valid_r && out_r.last))
    else $error("readout did not end with last");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the array insert/delete engine: directed table, then random commands
module tb_top;

  localparam int CAPACITY      = 16;
  localparam int RAND_ITEMS    = 454;
  localparam int QUIET_TAIL    = 60;
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 4;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_GROW,
    MIX_SHRINK,
    MIX_CHURN
  } mix_t;

  typedef struct {
    aide_pkg::in_t  cmd;
    bit             chk;
    aide_pkg::out_t res;
  } dir_row_t;

  logic clk      = 1'b0;
  logic rst_n    = 1'b0;
  logic start    = 1'b0;
  aide_pkg::in_t  in_item  = '0;
  logic busy;
  logic out_valid;
  aide_pkg::out_t out_item;

  bit             row_chk  = 1'b0;
  aide_pkg::out_t row_res  = '0;

  logic signed [aide_pkg::DATA_W-1:0] list_mem [CAPACITY];
  int   list_len       = 0;
  int   len_mirror     = 0;
  int   pending_mirror = 0;
  int   mismatches     = 0;
  aide_pkg::out_t expected_results [$];
  dir_row_t dir_tab [$];

  array_insert_delete_engine #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic aide_pkg::out_t mk_res(logic [31:0] data, int idx,
                                            aide_pkg::status_t st, int cnt, bit last);
    aide_pkg::out_t r;
    r.data   = data;
    r.index  = idx[aide_pkg::POS_W-1:0];
    r.status = st;
    r.count  = cnt[aide_pkg::CNT_W-1:0];
    r.last   = last;
    return r;
  endfunction

  function automatic aide_pkg::in_t mk_cmd(logic [2:0] op, int pos, logic [31:0] val);
    aide_pkg::in_t c;
    c.op       = aide_pkg::op_t'(op);
    c.position = pos[aide_pkg::POS_W-1:0];
    c.value    = val;
    return c;
  endfunction

  function automatic void add_row(logic [2:0] op, int pos, logic [31:0] val, bit chk,
                                  aide_pkg::status_t st, int cnt);
    dir_row_t row;
    row.cmd = mk_cmd(op, pos, val);
    row.chk = chk;
    row.res = mk_res(32'd0, 0, st, cnt, 1'b1);
    dir_tab.push_back(row);
  endfunction

  // list model: applies one command and queues the results it causes, or the table row's result when it is checked
  task automatic predict_list_op(aide_pkg::in_t c, bit use_row, aide_pkg::out_t row_exp);
    aide_pkg::out_t    found [$];
    aide_pkg::status_t st;
    int      i;
    int      pos;
    st  = aide_pkg::ST_OK;
    pos = int'(c.position);
    case (c.op)
      aide_pkg::OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          st = aide_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = c.value;
          list_len++;
        end
      end
      aide_pkg::OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          st = aide_pkg::ST_FULL;
        end else if (pos > list_len) begin
          st = aide_pkg::ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = c.value;
          list_len++;
        end
      end
      aide_pkg::OP_DELETE: begin
        if (pos >= list_len) begin
          st = aide_pkg::ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      aide_pkg::OP_UPDATE: begin
        if (pos >= list_len) st = aide_pkg::ST_RANGE;
        else list_mem[pos] = c.value;
      end
      default: ;
    endcase
    if (c.op == aide_pkg::OP_READ && list_len == 0) begin
      found.push_back(mk_res(32'd0, 0, aide_pkg::ST_EMPTY, 0, 1'b1));
    end else if (c.op == aide_pkg::OP_READ) begin
      for (i = 0; i < list_len; i++)
        found.push_back(mk_res(list_mem[i], i, aide_pkg::ST_OK, list_len, i + 1 == list_len));
    end else begin
      found.push_back(mk_res(32'd0, 0, st, list_len, 1'b1));
    end
    if (use_row) expected_results.push_back(row_exp);
    else foreach (found[j]) expected_results.push_back(found[j]);
  endtask

  function automatic aide_pkg::in_t gen_cmd(mix_t mode, int len);
    int         th [5];
    int         r;
    logic [2:0] op;
    int         pos;
    logic [31:0] val;
    bit         grow_only;
    grow_only = (mode == MIX_FILL) && (len < CAPACITY);
    case (mode)
      MIX_FILL:   th = '{30, 60, 65, 80, 95};
      MIX_GROW:   th = '{30, 60, 70, 85, 95};
      MIX_SHRINK: th = '{10, 20, 65, 80, 95};
      default:    th = '{20, 40, 60, 80, 95};
    endcase
    r = $urandom_range(0, 99);
    if (grow_only) op = (r < 60) ? aide_pkg::OP_APPEND : aide_pkg::OP_INSERT;
    else if (r < th[0]) op = aide_pkg::OP_APPEND;
    else if (r < th[1]) op = aide_pkg::OP_INSERT;
    else if (r < th[2]) op = aide_pkg::OP_DELETE;
    else if (r < th[3]) op = aide_pkg::OP_UPDATE;
    else if (r < th[4]) op = aide_pkg::OP_READ;
    else op = 3'($urandom_range(int'(OP_SPARE_A), int'(OP_SPARE_C)));

    if ((op == aide_pkg::OP_INSERT || op == aide_pkg::OP_DELETE ||
         op == aide_pkg::OP_UPDATE) &&
        (grow_only || $urandom_range(0, 99) < 85)) begin
      if (op == aide_pkg::OP_INSERT) pos = $urandom_range(0, len);
      else pos = (len > 0) ? $urandom_range(0, len - 1) : 0;
    end else begin
      pos = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 63);
    end

    case ($urandom_range(0, 15))
      0:       val = 32'h7fff_ffff;
      1:       val = 32'h8000_0000;
      2:       val = 32'h0000_0000;
      3:       val = 32'hffff_ffff;
      default: val = $urandom;
    endcase
    return mk_cmd(op, pos, val);
  endfunction

  task automatic send_cmd(aide_pkg::in_t c, bit chk, aide_pkg::out_t res);
    start   <= 1'b1;
    in_item <= c;
    row_chk <= chk;
    row_res <= res;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results();
    int k;
    start <= 1'b0;
    @(posedge clk);
    for (k = 0; k < 4 * CAPACITY + 100 && pending_mirror != 0; k++) @(posedge clk);
  endtask

  always @(posedge clk) begin
    aide_pkg::out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, data", 64'(out_item.data), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.data !== want.data)
            report_mismatch("data", 64'(out_item.data), 64'(want.data));
          if (out_item.index !== want.index)
            report_mismatch("index", 64'(out_item.index), 64'(want.index));
          if (out_item.status !== want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
          if (out_item.count !== want.count)
            report_mismatch("count", 64'(out_item.count), 64'(want.count));
          if (out_item.last !== want.last)
            report_mismatch("last", 64'(out_item.last), 64'(want.last));
        end
      end else if (out_valid !== 1'b0) begin
        report_mismatch("out_valid unknown", 64'(out_valid), 64'd0);
      end
      if (start && busy === 1'b0) predict_list_op(in_item, row_chk, row_res);
    end
    len_mirror     <= list_len;
    pending_mirror <= expected_results.size();
  end

  initial begin
    int   real_cnt;
    int   block;
    int   block_len;
    int   k;
    bit   quiet;
    mix_t mode;
    aide_pkg::in_t cmd;

    // edge cases on an empty list, then at both ends and in the middle
    add_row(aide_pkg::OP_READ,   0, 32'h0,         1, aide_pkg::ST_EMPTY, 0);
    add_row(aide_pkg::OP_DELETE, 0, 32'h0,         1, aide_pkg::ST_RANGE, 0);
    add_row(aide_pkg::OP_UPDATE, 0, 32'h1,         1, aide_pkg::ST_RANGE, 0);
    add_row(aide_pkg::OP_INSERT, 1, 32'h2,         1, aide_pkg::ST_RANGE, 0);
    add_row(aide_pkg::OP_INSERT, 0, 32'h7fff_ffff, 1, aide_pkg::ST_OK,    1);
    add_row(aide_pkg::OP_APPEND, 63, 32'h8000_0000, 1, aide_pkg::ST_OK,   2);
    add_row(aide_pkg::OP_INSERT, 1, 32'hffff_ffff, 1, aide_pkg::ST_OK,    3);
    add_row(aide_pkg::OP_INSERT, 3, 32'h0,         1, aide_pkg::ST_OK,    4);
    add_row(aide_pkg::OP_INSERT, 5, 32'h3,         1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_INSERT, 63, 32'h4,        1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_UPDATE, 4, 32'h5,         1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_UPDATE, 63, 32'h6,        1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_UPDATE, 0, 32'h5555_5555, 1, aide_pkg::ST_OK,    4);
    add_row(aide_pkg::OP_UPDATE, 3, 32'haaaa_aaaa, 1, aide_pkg::ST_OK,    4);
    add_row(aide_pkg::OP_READ,   0, 32'h0,         0, aide_pkg::ST_OK,    0);
    add_row(aide_pkg::OP_DELETE, 4, 32'h0,         1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_DELETE, 63, 32'h0,        1, aide_pkg::ST_RANGE, 4);
    add_row(aide_pkg::OP_DELETE, 1, 32'h0,         1, aide_pkg::ST_OK,    3);
    add_row(aide_pkg::OP_DELETE, 2, 32'h0,         1, aide_pkg::ST_OK,    2);
    add_row(OP_SPARE_A,          63, 32'hffff_ffff, 1, aide_pkg::ST_OK,   2);
    add_row(OP_SPARE_B,          0, 32'h0,         1, aide_pkg::ST_OK,    2);
    add_row(OP_SPARE_C,          42, 32'h1234_5678, 1, aide_pkg::ST_OK,   2);
    add_row(aide_pkg::OP_READ,   63, 32'hffff_ffff, 0, aide_pkg::ST_OK,   0);
    add_row(aide_pkg::OP_DELETE, 0, 32'h0,         1, aide_pkg::ST_OK,    1);
    add_row(aide_pkg::OP_DELETE, 0, 32'h0,         1, aide_pkg::ST_OK,    0);
    add_row(aide_pkg::OP_READ,   0, 32'h0,         1, aide_pkg::ST_EMPTY, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].res);
    drain_results();

    real_cnt = 0;
    block    = 0;
    while (real_cnt < RAND_ITEMS) begin
      mode      = (block == 0) ? MIX_FILL : mix_t'($urandom_range(0, 3));
      block_len = $urandom_range(20, 40);
      quiet     = ($urandom_range(0, 3) == 0);
      for (k = 0; k < block_len && real_cnt < RAND_ITEMS; k++) begin
        if (!quiet && real_cnt < RAND_ITEMS - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        cmd = gen_cmd(mode, (len_mirror > CAPACITY) ? CAPACITY : len_mirror);
        send_cmd(cmd, 1'b0, '0);
        real_cnt++;
      end
      if (block == 4) drain_results();
      block++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(expected_results.size()), 64'd0);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
